/* hw/rtl/ntp_pkg.sv */
// ----------------------------------------------------------------------------
// ntp_pkg
// Shared types and constants for the number text parser: character codes,
// prefix bases and the item formats passed between front, queue and back.
// ----------------------------------------------------------------------------
package ntp_pkg;

  localparam int VALUE_W = 16;

  // Input action codes
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_CHAR  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_LO_B  = 8'h62;  // 'b'
  localparam logic [7:0] CH_UP_B  = 8'h42;  // 'B'
  localparam logic [7:0] CH_LO_C  = 8'h63;  // 'c'
  localparam logic [7:0] CH_UP_C  = 8'h43;  // 'C'
  localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'
  localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  // Digit mapping constants
  localparam logic [7:0] DIGIT_MAX   = 8'd9;
  localparam logic [7:0] ALPHA_GAP   = 8'd7;
  localparam logic [7:0] UPPER_MAX   = 8'd35;
  localparam logic [7:0] DIGIT_COUNT = 8'd10;

  // Bases
  localparam logic [7:0] BASE_BIN     = 8'd2;
  localparam logic [7:0] BASE_OCT     = 8'd8;
  localparam logic [7:0] BASE_HEX     = 8'd16;
  localparam logic [7:0] BASE_DEFAULT = 8'd10;

  // Classified input item
  typedef struct packed {
    logic       is_begin;
    logic [7:0] length;
    logic [7:0] start_base;  // configured base, captured on begin items
    logic       is_minus;
    logic       is_zero;
    logic       has_sel;     // character selects a prefix base
    logic [7:0] sel_base;
    logic       digit_bad;   // not a digit in any base
    logic [7:0] digit;
  } ntp_item_t;

  // Result item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
  } ntp_result_t;

endpackage

/* hw/rtl/ntp_fifo.sv */
// ----------------------------------------------------------------------------
// ntp_fifo
// Small register-based queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module ntp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/ntp_front.sv */
// ----------------------------------------------------------------------------
// ntp_front
// Holds the base register and classifies each incoming item: sign, prefix
// zero, prefix selector and digit value, ready for the back end.
// ----------------------------------------------------------------------------
module ntp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_action,
  input  logic [7:0]        in_ch,
  input  logic [7:0]        in_length,
  output ntp_pkg::ntp_item_t item
);

  import ntp_pkg::*;

  logic [7:0] number_base_r;
  logic [7:0] d0, d1, d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_DEFAULT;
    end else if (cfg_wr_en) begin
      number_base_r <= cfg_wr_data;
    end
  end

  // letters map to 10..35; anything landing below 10 after the shift is bad
  assign d0 = in_ch - CH_ZERO;
  assign d1 = d0 - ALPHA_GAP;
  assign d2 = (d1 > UPPER_MAX) ? d1 - CH_SPACE : d1;

  always_comb begin
    item            = '0;
    item.is_begin   = (in_action == ACT_BEGIN);
    item.length     = in_length;
    item.start_base = number_base_r;
    item.is_minus   = (in_ch == CH_MINUS);
    item.is_zero    = (in_ch == CH_ZERO);
    if (d0 > DIGIT_MAX) begin
      item.digit     = d2;
      item.digit_bad = (d2 < DIGIT_COUNT);
    end else begin
      item.digit     = d0;
      item.digit_bad = 1'b0;
    end
    case (in_ch)
      CH_LO_B, CH_UP_B: begin
        item.has_sel  = 1'b1;
        item.sel_base = BASE_BIN;
      end
      CH_LO_C, CH_UP_C: begin
        item.has_sel  = 1'b1;
        item.sel_base = BASE_OCT;
      end
      CH_LO_X, CH_UP_X: begin
        item.has_sel  = 1'b1;
        item.sel_base = BASE_HEX;
      end
      default: begin
        item.has_sel  = 1'b0;
        item.sel_base = BASE_DEFAULT;
      end
    endcase
  end

endmodule

/* hw/rtl/ntp_back.sv */
// ----------------------------------------------------------------------------
// ntp_back
// Token state machine and multiply-accumulate. Takes one classified item
// per cycle while take is high and pushes at most one result.
// ----------------------------------------------------------------------------
module ntp_back #(
  parameter int CELL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  ntp_pkg::ntp_item_t    item,
  output logic                  res_push,
  output ntp_pkg::ntp_result_t  res
);

  import ntp_pkg::*;

  typedef enum logic [1:0] {
    PFX_CHECK,
    PFX_SEL,
    PFX_DIGITS
  } pfx_state_t;

  pfx_state_t           stage_r, stage_nxt;
  logic [7:0]           chars_left_r, chars_left_nxt;
  logic                 first_r, first_nxt;
  logic                 neg_r, neg_nxt;
  logic [7:0]           wb_r, wb_nxt;
  logic [CELL_BITS-1:0] acc_r, acc_nxt;
  logic                 failed_r, failed_nxt;

  logic [CELL_BITS-1:0] prod;
  logic [CELL_BITS-1:0] mac;
  logic [CELL_BITS-1:0] signed_val;
  logic                 do_digit;

  // only the low cell bits of the product are kept
  assign prod = acc_r * CELL_BITS'(wb_r);
  assign mac  = prod + CELL_BITS'(item.digit);
  assign signed_val = neg_nxt ? (CELL_BITS'(0) - acc_nxt) : acc_nxt;

  always_comb begin
    stage_nxt      = stage_r;
    chars_left_nxt = chars_left_r;
    first_nxt      = first_r;
    neg_nxt        = neg_r;
    wb_nxt         = wb_r;
    acc_nxt        = acc_r;
    failed_nxt     = failed_r;
    do_digit       = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    if (take) begin
      if (item.is_begin) begin
        chars_left_nxt = item.length;
        first_nxt      = 1'b1;
        neg_nxt        = 1'b0;
        stage_nxt      = PFX_CHECK;
        wb_nxt         = item.start_base;
        acc_nxt        = '0;
        failed_nxt     = 1'b0;
        if (item.length == 8'd0) begin
          res_push  = 1'b1;
          res.error = 1'b1;
        end
      end else if (chars_left_r != 8'd0) begin
        unique case (stage_r)
          PFX_CHECK: begin
            if (first_r && item.is_minus) begin
              neg_nxt = 1'b1;
            end else if (chars_left_r > 8'd2 && item.is_zero) begin
              stage_nxt = PFX_SEL;
            end else begin
              stage_nxt = PFX_DIGITS;
              // 128 or more digit characters left
              if (chars_left_r[7]) begin
                failed_nxt = 1'b1;
              end
              do_digit = 1'b1;
            end
          end
          PFX_SEL: begin
            if (item.has_sel) begin
              wb_nxt = item.sel_base;
            end
            stage_nxt = PFX_DIGITS;
            // selector is the last char, or 128+ digits follow it
            if (chars_left_r == 8'd1 || chars_left_r > 8'd128) begin
              failed_nxt = 1'b1;
            end
          end
          PFX_DIGITS: begin
            do_digit = 1'b1;
          end
          default: begin
            stage_nxt = PFX_DIGITS;
          end
        endcase
        if (do_digit && !failed_nxt) begin
          if (item.digit_bad || item.digit >= wb_r) begin
            failed_nxt = 1'b1;
          end else begin
            acc_nxt = mac;
          end
        end
        chars_left_nxt = chars_left_r - 8'd1;
        first_nxt      = 1'b0;
        if (chars_left_r == 8'd1) begin
          res_push = 1'b1;
          if (stage_nxt != PFX_DIGITS || failed_nxt) begin
            res.error = 1'b1;
          end else begin
            res.value = VALUE_W'(signed_val);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r      <= PFX_CHECK;
      chars_left_r <= 8'd0;
      first_r      <= 1'b1;
      neg_r        <= 1'b0;
      wb_r         <= BASE_DEFAULT;
      acc_r        <= '0;
      failed_r     <= 1'b0;
    end else begin
      stage_r      <= stage_nxt;
      chars_left_r <= chars_left_nxt;
      first_r      <= first_nxt;
      neg_r        <= neg_nxt;
      wb_r         <= wb_nxt;
      acc_r        <= acc_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule

/* hw/rtl/number_text_parser_core.sv */
// ----------------------------------------------------------------------------
// number_text_parser_core
// Converts a counted text token into a signed cell-wide integer.
// ----------------------------------------------------------------------------
// Input channel (push/full): a begin item (in_action 0) carries the token
// length, then one character item (in_action 1) per character follows.
// Result channel (empty/pop): one item per token with out_value and
// out_error, given after the last character, or right after a begin item
// whose length is zero; a token cut short by a begin item gives none.
// Configuration: cfg_wr_en writes cfg_wr_data into the default base; write
// it only while no token is in flight.
// Throughput: one item per cycle unless the result queue is full. The back
// end's single multiply-accumulate retires one character each unstalled cycle.
// Path: an accepted item is registered in the item queue; the back end then
// writes its result into the result queue, whose head drives the outputs.
// A queue between the classifier and the back end, and a result queue, let
// each side stall on its own: when pop is held low the result queue fills,
// then the back end stops, then full rises on the input.
// Reset (synchronous, rst_n low): queues empty, base back to ten, no token
// open.
// ----------------------------------------------------------------------------
module number_text_parser_core #(
  parameter int CELL_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [7:0]                  cfg_wr_data,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_action,
  input  logic [7:0]                  in_ch,
  input  logic [7:0]                  in_length,
  output logic                        empty,
  input  logic                        pop,
  output logic [ntp_pkg::VALUE_W-1:0] out_value,
  output logic                        out_error
);

  import ntp_pkg::*;

  ntp_item_t   front_item;
  ntp_item_t   mid_item;
  logic        mid_empty;
  logic        take;
  logic        res_push;
  logic        res_full;
  ntp_result_t res;
  ntp_result_t res_head;

  ntp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_action   (in_action),
    .in_ch       (in_ch),
    .in_length   (in_length),
    .item        (front_item)
  );

  ntp_fifo #(
    .WIDTH ($bits(ntp_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_item),
    .full    (full),
    .pop     (take),
    .rd_data (mid_item),
    .empty   (mid_empty)
  );

  assign take = !mid_empty && !res_full;

  ntp_back #(
    .CELL_BITS (CELL_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (mid_item),
    .res_push (res_push),
    .res      (res)
  );

  ntp_fifo #(
    .WIDTH ($bits(ntp_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign out_value = res_head.value;
  assign out_error = res_head.error;

endmodule

/* bench/tb_number_text_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_number_text_parser_core
// Self-checking bench for the number text parser. Tokens go in as a begin
// item plus character items; a local parse model predicts each token result
// and a monitor compares every popped item against the oldest prediction.
// Covers signs, radix prefixes, bad digits, empty, long and abandoned tokens,
// stray characters, odd and extreme base settings and back-pressure.
// ----------------------------------------------------------------------------
module tb_number_text_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ntp_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 12;
  localparam int RANDOM_ITEMS = 470;
  localparam int MAX_DIGITS   = 128;

  localparam logic [7:0] CH_UP_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_LO_A = 8'h61;  // 'a'

  typedef enum logic [1:0] {STG_PREFIX, STG_SELECT, STG_DIGITS} stage_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [7:0]         cfg_wr_data;
  logic               push;
  logic               full;
  logic               in_action;
  logic [7:0]         in_ch;
  logic [7:0]         in_length;
  logic               empty;
  logic               pop;
  logic [VALUE_W-1:0] out_value;
  logic               out_error;

  number_text_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .in_action  (in_action),
    .in_ch      (in_ch),
    .in_length  (in_length),
    .empty      (empty),
    .pop        (pop),
    .out_value  (out_value),
    .out_error  (out_error)
  );

  always #5 clk = ~clk;

  // parse model state
  logic [7:0]         m_base;
  logic [7:0]         m_left;
  logic [7:0]         m_index;
  logic               m_neg;
  stage_t             m_stage;
  logic [7:0]         m_wbase;
  logic [VALUE_W-1:0] m_acc;
  logic               m_bad;

  ntp_result_t token_results_q[$];
  logic [7:0]  tok_chars[$];

  bit idling_on     = 1'b1;
  bit hold_request  = 1'b0;
  int pop_stall     = 0;
  int items_sent    = 0;
  int results_ok    = 0;
  int results_err   = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int bases_written = 0;

  // -1 for characters that map below ten after the letter fold
  function automatic int digit_of(logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (d > DIGIT_MAX) begin
      d = d - ALPHA_GAP;
      if (d > UPPER_MAX) d = d - CH_SPACE;
      if (d < DIGIT_COUNT) return -1;
    end
    return int'(d);
  endfunction

  function automatic logic [7:0] pick_digit(logic [7:0] b);
    int v;
    logic [7:0] c;
    if (b <= 1) return CH_ZERO;
    if (b <= 36 || $urandom_range(0, 1) == 0) begin
      v = $urandom_range(0, (b > 36) ? 35 : b - 1);
      if (v < 10) return CH_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
    end
    c = CH_ZERO;
    repeat (40) begin
      c = 8'($urandom_range(0, 255));
      if (digit_of(c) >= 0 && digit_of(c) < int'(b)) return c;
    end
    return c;
  endfunction

  task automatic reset_model();
    m_base  = BASE_DEFAULT;
    m_left  = '0;
    m_index = '0;
    m_neg   = 1'b0;
    m_stage = STG_PREFIX;
    m_wbase = BASE_DEFAULT;
    m_acc   = '0;
    m_bad   = 1'b0;
  endtask

  task automatic accumulate(logic [7:0] c);
    int d;
    d = digit_of(c);
    if (m_bad) return;
    if (d < 0 || d >= int'(m_wbase)) begin
      m_bad = 1'b1;
      return;
    end
    m_acc = VALUE_W'(m_acc * m_wbase + d);
  endtask

  task automatic open_digits(int remaining);
    m_stage = STG_DIGITS;
    if (remaining == 0 || remaining >= MAX_DIGITS) m_bad = 1'b1;
  endtask

  // advances the parse model by one accepted item
  task automatic track_token_item(logic act, logic [7:0] c, logic [7:0] len);
    ntp_result_t r;
    if (act == ACT_BEGIN) begin
      m_left  = len;
      m_index = '0;
      m_neg   = 1'b0;
      m_stage = STG_PREFIX;
      m_wbase = m_base;
      m_acc   = '0;
      m_bad   = 1'b0;
      if (len == 0) begin
        r.value = '0;
        r.error = 1'b1;
        token_results_q.push_back(r);
      end
      return;
    end
    if (m_left == 0) return;  // stray character
    case (m_stage)
      STG_PREFIX: begin
        if (m_index == 0 && c == CH_MINUS) m_neg = 1'b1;
        else if (m_left > 2 && c == CH_ZERO) m_stage = STG_SELECT;
        else begin
          open_digits(int'(m_left));
          accumulate(c);
        end
      end
      STG_SELECT: begin
        if (c == CH_LO_B || c == CH_UP_B) m_wbase = BASE_BIN;
        else if (c == CH_LO_C || c == CH_UP_C) m_wbase = BASE_OCT;
        else if (c == CH_LO_X || c == CH_UP_X) m_wbase = BASE_HEX;
        open_digits(int'(m_left) - 1);
      end
      default: accumulate(c);
    endcase
    m_left  = m_left - 8'd1;
    m_index = m_index + 8'd1;
    if (m_left != 0) return;
    if (m_stage != STG_DIGITS) m_bad = 1'b1;
    r.error = m_bad;
    r.value = m_bad ? '0 : (m_neg ? VALUE_W'(0) - m_acc : m_acc);
    token_results_q.push_back(r);
  endtask

  task automatic send_item(logic act, logic [7:0] c, logic [7:0] len);
    int gap;
    if (idling_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push      <= 1'b1;
    in_action <= act;
    in_ch     <= c;
    in_length <= len;
    do @(posedge clk); while (full);
    track_token_item(act, c, len);
    items_sent++;
  endtask

  // len < 0: characters only, no begin item
  task automatic send_token(int len);
    if (len >= 0) send_item(ACT_BEGIN, 8'($urandom_range(0, 255)), 8'(len));
    foreach (tok_chars[i]) send_item(ACT_CHAR, tok_chars[i], 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    tok_chars.delete();
    for (int i = 0; i < s.len(); i++) tok_chars.push_back(s[i]);
    send_token(s.len());
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    push <= 1'b0;
    while (token_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(logic [7:0] b);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_base = b;
    bases_written++;
  endtask

  task automatic build_random_token(output int len);
    int kind, ndig, sel;
    logic [7:0] b, c;
    tok_chars.delete();
    kind = $urandom_range(0, 19);
    b = m_base;
    len = 0;
    if (kind < 15) begin
      if ($urandom_range(0, 3) == 0) tok_chars.push_back(CH_MINUS);
      sel = $urandom_range(0, 7);
      if (sel < 4) begin
        tok_chars.push_back(CH_ZERO);
        case (sel)
          0: begin
            tok_chars.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            b = BASE_HEX;
          end
          1: begin
            tok_chars.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
            b = BASE_BIN;
          end
          2: begin
            tok_chars.push_back($urandom_range(0, 1) ? CH_LO_C : CH_UP_C);
            b = BASE_OCT;
          end
          default: tok_chars.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      ndig = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
      repeat (ndig) tok_chars.push_back(pick_digit(b));
      len = tok_chars.size();
      // cut short: the next begin item abandons it
      if (kind >= 13) len = len + $urandom_range(1, 4);
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0: c = CH_MINUS;
            1: c = CH_ZERO;
            2: c = CH_UP_B;
            3: c = CH_LO_C;
            default: c = CH_SPACE;
          endcase
        end else c = 8'($urandom_range(0, 255));
        tok_chars.push_back(c);
      end
      len = tok_chars.size();
    end else if (kind == 18) begin
      tok_chars.push_back(8'($urandom_range(0, 255)));
      len = -1;
    end
  endtask

  task automatic test_directed_tokens();
    send_text("");
    send_text("-");
    send_text("-0x1F");
    send_text("09");
    send_text("0z7");
    send_text("1g");
    tok_chars = '{8'hFF};
    send_token(-1);
    // long token dropped by a new begin
    tok_chars = '{8'h00};
    send_token(255);
    send_text("0B1");
  endtask

  task automatic test_base_register();
    logic [7:0] bases[0:6];
    string words[0:3];
    int len;
    bases = '{BASE_BIN, 8'd255, BASE_HEX, 8'd0, 8'd1, 8'd36, BASE_DEFAULT};
    words = '{"101", "-Zz", "0c17", "0b11"};
    foreach (bases[i]) begin
      write_base(bases[i]);
      foreach (words[j]) send_text(words[j]);
      build_random_token(len);
      send_token(len);
      send_text("0");
    end
  endtask

  task automatic test_backpressure();
    idling_on = 1'b0;
    hold_request = 1'b1;
    repeat (20) send_text("-42");
    wait_for_results();
    idling_on = 1'b1;
  endtask

  task automatic test_long_tokens();
    tok_chars.delete();
    repeat (MAX_DIGITS - 1) tok_chars.push_back(pick_digit(m_base));
    send_token(MAX_DIGITS - 1);
    tok_chars.push_back(pick_digit(m_base));
    send_token(MAX_DIGITS);
  endtask

  task automatic test_random_tokens();
    logic [7:0] bases[0:8];
    int stop_at, len;
    bases = '{BASE_DEFAULT, BASE_HEX, 8'd255, BASE_BIN, 8'd36,
              8'($urandom_range(2, 255)), 8'd0, 8'd1, BASE_DEFAULT};
    foreach (bases[p]) begin
      write_base(bases[p]);
      idling_on = (p != 4 && p != 8);
      stop_at = items_sent + RANDOM_ITEMS / 9;
      while (items_sent < stop_at) begin
        build_random_token(len);
        send_token(len);
      end
      send_text("1");  // leaves no token open
    end
  endtask

  // result side: random pop stalls plus one long hold on request
  initial begin
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        pop <= 1'b1;
      end else if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else begin
        pop <= 1'b1;
        if (idling_on && $urandom_range(0, 11) == 0) pop_stall = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (token_results_q.size() == 0) begin
        $error("result item with nothing pending: out_value %h out_error %b",
               out_value, out_error);
        mismatches++;
      end else begin
        if (out_value !== token_results_q[0].value) begin
          $error("out_value: expected %h, actual %h", token_results_q[0].value, out_value);
          mismatches++;
        end
        if (out_error !== token_results_q[0].error) begin
          $error("out_error: expected %b, actual %b", token_results_q[0].error, out_error);
          mismatches++;
        end
        if (token_results_q[0].error) results_err++;
        else results_ok++;
        void'(token_results_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    push        = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_action   = ACT_BEGIN;
    in_ch       = '0;
    in_length   = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_tokens();
    test_base_register();
    test_backpressure();
    test_long_tokens();
    test_random_tokens();
    wait_for_results();

    $display("%0d items sent, %0d numbers parsed, %0d tokens rejected, %0d base writes",
             items_sent, results_ok, results_err, bases_written);
    $display("prefixes, signs, bad digits, long/empty/abandoned tokens, back-pressure");
    if (mismatches == 0 && token_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
